FILE: hdl/swm_pkg.sv
// Shared types for the sliding window median filter.
// Used by the cell chain and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    // width of the window_len configuration register
    localparam int CFG_W = 7;

    // handed from each cell to its right neighbor
    typedef struct packed {
        logic evict_seen;   // the evicted entry sits at or left of this cell
        logic less;         // this cell's compacted entry is below the new key
    } swm_link_t;

    // broadcast to every cell
    typedef struct packed {
        logic load;         // an item is accepted this cycle
        logic full;         // window is full, the oldest entry goes out
    } swm_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/swm_cell.sv
// One cell of the sorted window: holds one sample and its age.
// Depends on swm_pkg for the link and control structs.
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int IDX         = 0,
    parameter int SAMPLE_BITS = 32,
    parameter int AGE_W       = 6,
    parameter int FILL_W      = 7
) (
    input  wire logic                          aclk,
    input  wire swm_pkg::swm_ctl_t             ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] key,
    input  wire logic [AGE_W-1:0]              max_age,
    input  wire logic [FILL_W-1:0]             fill,
    input  wire swm_pkg::swm_link_t            link_in,
    input  wire logic signed [SAMPLE_BITS-1:0] left_val,
    input  wire logic [AGE_W-1:0]              left_age,
    input  wire logic signed [SAMPLE_BITS-1:0] right_val,
    input  wire logic [AGE_W-1:0]              right_age,
    output swm_pkg::swm_link_t                 link_out,
    output logic signed [SAMPLE_BITS-1:0]      w_val,
    output logic [AGE_W-1:0]                   w_age,
    output logic signed [SAMPLE_BITS-1:0]      val,
    output logic [AGE_W-1:0]                   age
);

    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    logic [AGE_W-1:0]              age_reg, age_next;
    logic                          valid, right_valid, w_valid, evict, evict_seen, less;

    assign valid       = FILL_W'(IDX) < fill;
    assign right_valid = FILL_W'(IDX + 1) < fill;

    // only one valid entry can have the maximum age when the window is full
    assign evict      = ctl.full && valid && (age_reg == max_age);
    assign evict_seen = link_in.evict_seen | evict;

    // entry at this place once the evicted one is squeezed out
    always_comb begin
        if (evict_seen) begin
            w_val   = right_val;
            w_age   = right_age;
            w_valid = right_valid;
        end else begin
            w_val   = val_reg;
            w_age   = age_reg;
            w_valid = valid;
        end
    end

    assign less = w_valid && (w_val < key);

    // keep, take the new key, or take the left neighbor's entry;
    // the key lands in the first cell whose left side is still below it
    always_comb begin
        if (less) begin
            val_next = w_val;
            age_next = w_age + AGE_W'(1);
        end else if (link_in.less) begin
            val_next = key;
            age_next = '0;
        end else begin
            val_next = left_val;
            age_next = left_age + AGE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign link_out = '{evict_seen: evict_seen, less: less};
    assign val      = val_reg;
    assign age      = age_reg;

endmodule

`default_nettype wire

FILE: hdl/sliding_window_median.sv
// Sliding window median filter: keeps the last window_len samples sorted in a row
// of cells, one cell per window slot, and gives the lower median of the window for
// each sample once window_len samples have arrived since reset or the last write to
// window_len (a write restarts filling; 0 acts as 1, values above WINDOW_MAX act as
// WINDOW_MAX). One item is accepted per clock while s_tready is high: the cell
// chain evicts the oldest sample and inserts the new one in the same update. The
// median is picked from the cells into the output register once they hold the new
// sample and the output register is free, so an accepted item passes the cell
// registers and then the output register before m_tvalid rises; input stalls only
// while a result waits behind an output register that is full and not being taken.
// Depends on swm_pkg and swm_cell.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_median #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    // configuration
    input  wire logic                     cfg_wr_en,
    input  wire logic [swm_pkg::CFG_W-1:0] cfg_wr_data,    // window_len
    // samples in
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata, // [SAMPLE_BITS-1:0] sample
    // medians out
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata       // [SAMPLE_BITS-1:0] median
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int AGE_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);

    logic [FILL_W-1:0]      len_reg, len_next, len_cfg;
    logic [AGE_W-1:0]       max_age_reg, max_age_next;
    logic [AGE_W-1:0]       med_reg, med_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic                   pend_reg, pend_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_BITS-1:0] m_data_reg, m_data_next;

    logic                   accept, full, produces, out_free, load_out;
    logic signed [SAMPLE_BITS-1:0] key;
    swm_pkg::swm_ctl_t      ctl;

    logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
    logic [AGE_W-1:0]              cell_age [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_val    [WINDOW_MAX];
    logic [AGE_W-1:0]              w_age    [WINDOW_MAX];
    swm_pkg::swm_link_t            link     [WINDOW_MAX];

    assign key      = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = pend_reg && out_free;
    assign s_tready = !pend_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign full     = (fill_reg == len_reg);
    assign produces = full || ((fill_reg + FILL_W'(1)) == len_reg);

    assign ctl = '{load: accept, full: full};

    // clamp window_len to 1..WINDOW_MAX
    always_comb begin
        if (cfg_wr_data == '0) begin
            len_cfg = FILL_W'(1);
        end else if (int'(cfg_wr_data) > WINDOW_MAX) begin
            len_cfg = FILL_W'(WINDOW_MAX);
        end else begin
            len_cfg = FILL_W'(cfg_wr_data);
        end
    end

    always_comb begin
        len_next     = len_reg;
        max_age_next = max_age_reg;
        med_next     = med_reg;
        fill_next    = fill_reg;
        if (cfg_wr_en) begin
            len_next     = len_cfg;
            max_age_next = AGE_W'(len_cfg - FILL_W'(1));
            med_next     = AGE_W'((len_cfg - FILL_W'(1)) >> 1);
            fill_next    = '0;
        end else if (accept && !full) begin
            fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_comb begin
        if (accept) begin
            pend_next = produces;
        end else if (load_out) begin
            pend_next = 1'b0;
        end else begin
            pend_next = pend_reg;
        end

        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // one-hot pick of the median cell
    always_comb begin
        m_data_next = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            if (AGE_W'(j) == med_reg) begin
                m_data_next = m_data_next | cell_val[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= FILL_W'(1);
            max_age_reg  <= '0;
            med_reg      <= '0;
            fill_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            len_reg      <= len_next;
            max_age_reg  <= max_age_next;
            med_reg      <= med_next;
            fill_reg     <= fill_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(m_data_reg);

    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
        swm_pkg::swm_link_t            l_link;
        logic signed [SAMPLE_BITS-1:0] l_val, r_val;
        logic [AGE_W-1:0]              l_age, r_age;

        if (j == 0) begin : g_first
            // the left edge counts as below any key
            assign l_link = '{evict_seen: 1'b0, less: 1'b1};
            assign l_val  = '0;
            assign l_age  = '0;
        end else begin : g_mid
            assign l_link = link[j-1];
            assign l_val  = w_val[j-1];
            assign l_age  = w_age[j-1];
        end

        if (j == WINDOW_MAX - 1) begin : g_last
            assign r_val = '0;
            assign r_age = '0;
        end else begin : g_inner
            assign r_val = cell_val[j+1];
            assign r_age = cell_age[j+1];
        end

        swm_cell #(
            .IDX        (j),
            .SAMPLE_BITS(SAMPLE_BITS),
            .AGE_W      (AGE_W),
            .FILL_W     (FILL_W)
        ) u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .key      (key),
            .max_age  (max_age_reg),
            .fill     (fill_reg),
            .link_in  (l_link),
            .left_val (l_val),
            .left_age (l_age),
            .right_val(r_val),
            .right_age(r_age),
            .link_out (link[j]),
            .w_val    (w_val[j]),
            .w_age    (w_age[j]),
            .val      (cell_val[j]),
            .age      (cell_age[j])
        );
    end

endmodule

`default_nettype wire

FILE: hdl/swm_checker.sv
// Port-level checks for the sliding window median filter, bound to the top level.
// Depends only on the top level's stream ports.
`timescale 1ns / 1ps
`default_nettype none

module swm_checker #(
    parameter int SAMPLE_BITS = 32
) (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_tvalid,
    input wire logic                                s_tready,
    input wire logic                                m_tvalid,
    input wire logic                                m_tready,
    input wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // input backs up only behind a stalled result
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // a new result goes back to an earlier accepted input item
    a_rise_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result item without an accepted input item");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind sliding_window_median swm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_swm_checker (.*);

`default_nettype wire
